>>> rtl/nsla_pkg.sv
// Shared types and result codes for the named slot lookup and allocate table.
`default_nettype none
package nsla_pkg;

  // Result codes
  localparam logic [2:0] OUT_FOUND     = 3'd0;
  localparam logic [2:0] OUT_ALLOCATED = 3'd1;
  localparam logic [2:0] OUT_BAD_LEN   = 3'd2;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd3;
  localparam logic [2:0] OUT_FULL      = 3'd4;

  // Request select
  localparam logic REQ_FIND    = 1'b0;
  localparam logic REQ_ACQUIRE = 1'b1;

  // One streamed name byte with its request info
  typedef struct packed {
    logic       req_type;
    logic [7:0] name_len;
    logic [7:0] name_byte;
    logic       byte_last;
  } req_t;

  // One lookup result
  typedef struct packed {
    logic [2:0] outcome;
    logic [2:0] slot_index;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/named_slot_lookup_allocate.sv
// Named slot table: streams a name per request, then finds or allocates a slot.
// Name bytes are taken one per cycle while no lookup is running.
// After the last item the name memory is swept one byte position at a time (read,
// then compare all slots), over min(len, NAME_MAX_LEN-1)+1 positions, then the
// result is resolved; an allocation adds a write sweep over all NAME_MAX_LEN
// positions, then the result register is loaded. Bad lengths skip the sweeps.
// Reset clears the used flags and control; name memories need no clearing.
`default_nettype none
module named_slot_lookup_allocate #(
  parameter int NAME_MAX_LEN = 32,
  parameter int SLOT_COUNT   = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire nsla_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output nsla_pkg::rsp_t     rsp
);
  import nsla_pkg::*;

  localparam int POS_W  = $clog2(NAME_MAX_LEN + 1);
  localparam int IDX_W  = (NAME_MAX_LEN > 1) ? $clog2(NAME_MAX_LEN) : 1;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [2:0] ST_RECV    = 3'd0;
  localparam logic [2:0] ST_RD      = 3'd1;
  localparam logic [2:0] ST_CMP     = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_WRD     = 3'd4;
  localparam logic [2:0] ST_WST     = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  // Name memory: one row per byte position, one byte lane per slot
  logic [8*SLOT_COUNT-1:0] name_mem [NAME_MAX_LEN];
  logic [7:0]              stg_mem  [NAME_MAX_LEN];
  logic [8*SLOT_COUNT-1:0] row_q;
  logic [7:0]              stg_q;

  logic [2:0]            state;
  logic [IDX_W-1:0]      sweep_idx;
  logic [POS_W-1:0]      byte_position;
  logic [SLOT_COUNT-1:0] slot_used;
  logic [SLOT_COUNT-1:0] match_vec;
  logic                  req_q;
  logic [7:0]            len_q;
  logic [2:0]            res_outcome;
  logic [SLOT_W-1:0]     res_slot;

  logic                  acc;
  logic                  stage_en;
  logic [7:0]            pos8;
  logic [7:0]            last_pos;
  logic [7:0]            eff_byte;
  logic [SLOT_COUNT-1:0] eq_vec;
  logic                  hit;
  logic [SLOT_W-1:0]     hit_slot;
  logic                  has_free;
  logic [SLOT_W-1:0]     free_slot;

  assign req_stall = (state != ST_RECV);
  assign acc       = req_valid && !req_stall;

  // Stage a byte while it is within both the declared and the maximum length
  assign stage_en = acc && (req.name_len != 8'd0) &&
                    (byte_position < POS_W'(NAME_MAX_LEN)) &&
                    (8'(byte_position) < req.name_len);

  // Request byte at the sweep position; unstaged or past-length bytes are zero
  assign pos8     = 8'(sweep_idx);
  assign last_pos = (len_q == 8'(NAME_MAX_LEN)) ? 8'(NAME_MAX_LEN - 1) : len_q;
  assign eff_byte = ((pos8 < 8'(byte_position)) && (pos8 < len_q)) ? stg_q : 8'd0;

  // Per-slot byte compare at the current position
  always_comb begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      eq_vec[s] = (row_q[s*8 +: 8] == eff_byte);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    has_free  = 1'b0;
    free_slot = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (match_vec[s]) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
      if (!slot_used[s]) begin
        has_free  = 1'b1;
        free_slot = SLOT_W'(s);
      end
    end
  end

  // Staging memory
  always_ff @(posedge clk) begin
    if (stage_en) begin
      stg_mem[byte_position[IDX_W-1:0]] <= req.name_byte;
    end
    if (state inside {ST_RD, ST_WRD}) begin
      stg_q <= stg_mem[sweep_idx];
    end
  end

  // Name memory with byte-lane write for the allocated slot
  always_ff @(posedge clk) begin
    if (state == ST_WST) begin
      name_mem[sweep_idx][res_slot*8 +: 8] <= eff_byte;
    end
    if (state == ST_RD) begin
      row_q <= name_mem[sweep_idx];
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      sweep_idx     <= '0;
      byte_position <= '0;
      slot_used     <= '0;
      match_vec     <= '1;
      rsp_valid     <= 1'b0;
    end else begin
      // Result valid: set out of the final state, cleared once taken
      if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (stage_en) begin
        byte_position <= byte_position + POS_W'(1);
      end
      case (state)
        ST_RECV: begin
          if (acc && req.byte_last) begin
            req_q <= req.req_type;
            len_q <= req.name_len;
            if (req.name_len == 8'd0 || req.name_len > 8'(NAME_MAX_LEN)) begin
              res_outcome <= OUT_BAD_LEN;
              res_slot    <= '0;
              state       <= ST_DONE;
            end else begin
              match_vec <= slot_used;
              sweep_idx <= '0;
              state     <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          match_vec <= match_vec & eq_vec;
          if (pos8 == last_pos) begin
            state <= ST_RESOLVE;
          end else begin
            sweep_idx <= sweep_idx + IDX_W'(1);
            state     <= ST_RD;
          end
        end
        ST_RESOLVE: begin
          if (hit) begin
            res_outcome <= OUT_FOUND;
            res_slot    <= hit_slot;
            state       <= ST_DONE;
          end else if (req_q == REQ_ACQUIRE && has_free) begin
            res_outcome          <= OUT_ALLOCATED;
            res_slot             <= free_slot;
            slot_used[free_slot] <= 1'b1;
            sweep_idx            <= '0;
            state                <= ST_WRD;
          end else begin
            res_outcome <= (req_q == REQ_ACQUIRE) ? OUT_FULL : OUT_NOT_FOUND;
            res_slot    <= '0;
            state       <= ST_DONE;
          end
        end
        ST_WRD: begin
          state <= ST_WST;
        end
        ST_WST: begin
          if (sweep_idx == IDX_W'(NAME_MAX_LEN - 1)) begin
            state <= ST_DONE;
          end else begin
            sweep_idx <= sweep_idx + IDX_W'(1);
            state     <= ST_WRD;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            byte_position <= '0;
            match_vec     <= '1;
            state         <= ST_RECV;
          end
        end
        default: begin
          state <= ST_RECV;
        end
      endcase
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.outcome    <= res_outcome;
      rsp.slot_index <= 3'(res_slot);
    end
  end

  // A new result only appears out of the final state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside final state");

  // Misses and rejects carry slot zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome == OUT_BAD_LEN || rsp.outcome == OUT_NOT_FOUND ||
                  rsp.outcome == OUT_FULL) |-> rsp.slot_index == 3'd0)
    else $error("nonzero slot on miss");

  // An allocation claims exactly one more slot
  a_alloc_claims: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE && !hit && req_q == REQ_ACQUIRE && has_free) |=>
      $countones(slot_used) == $countones($past(slot_used)) + 1)
    else $error("allocation did not claim a slot");

  // Write sweep only runs for an allocation
  a_write_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRD || state == ST_WST) |-> res_outcome == OUT_ALLOCATED)
    else $error("name write without allocation");

  // No input is taken while a lookup runs
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP || state == ST_WST) |=> !$past(acc))
    else $error("item taken during lookup");

endmodule
`default_nettype wire
